FILE: rtl/core/top_three_jet_selector_unit_defines.svh
// assertion macros for the top three jet selector
// no dependencies; included by the top level, which carries the checks
`ifndef TOP_THREE_JET_SELECTOR_UNIT_DEFINES_SVH
`define TOP_THREE_JET_SELECTOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TTJS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define TTJS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/ttjs_pkg.sv
// shared constants and types for the top three jet selector
// no dependencies; used by the interfaces, the slot cell and the top level
package ttjs_pkg;

   localparam int PT_BITS_DEF   = 16;
   localparam int ETA_BITS      = 12;
   localparam int PHI_BITS      = 11;
   localparam int ANGLE_BITS    = 10;
   localparam int NSLOTS        = 3;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 10;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SIM_MODE  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ANGLE = 1'b1;

   localparam logic [ANGLE_BITS-1:0] MAX_ANGLE_RST = 10'd205;

   // what one cell tells the cell below it
   typedef struct packed {
      logic take;
      logic filled;
   } link_type;

endpackage

FILE: rtl/core/ttjs_req_if.sv
// request channel: one jet per item
// depends on ttjs_pkg
interface ttjs_req_if #(
   parameter int PT_BITS = ttjs_pkg::PT_BITS_DEF
);
   import ttjs_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [PT_BITS-1:0]          reco_pt;
   logic signed [ETA_BITS-1:0]  reco_eta;
   logic signed [PHI_BITS-1:0]  reco_phi;
   logic [PT_BITS-1:0]          gen_pt;
   logic [ANGLE_BITS-1:0]       match_angle;
   logic                        last_jet;

   modport source (
      output valid, reco_pt, reco_eta, reco_phi, gen_pt, match_angle, last_jet,
      input  ready
   );

   modport sink (
      input  valid, reco_pt, reco_eta, reco_phi, gen_pt, match_angle, last_jet,
      output ready
   );

endinterface

FILE: rtl/core/ttjs_rsp_if.sv
// response channel: the three ranked jets of one event per item
// depends on ttjs_pkg
interface ttjs_rsp_if #(
   parameter int PT_BITS = ttjs_pkg::PT_BITS_DEF
);
   import ttjs_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [PT_BITS-1:0]          first_pt;
   logic signed [ETA_BITS-1:0]  first_eta;
   logic signed [PHI_BITS-1:0]  first_phi;
   logic [PT_BITS-1:0]          first_gen_pt;
   logic [PT_BITS-1:0]          second_pt;
   logic signed [ETA_BITS-1:0]  second_eta;
   logic signed [PHI_BITS-1:0]  second_phi;
   logic [PT_BITS-1:0]          second_gen_pt;
   logic [PT_BITS-1:0]          third_pt;
   logic signed [ETA_BITS-1:0]  third_eta;
   logic signed [PHI_BITS-1:0]  third_phi;
   logic [PT_BITS-1:0]          third_gen_pt;

   modport source (
      output valid,
      output first_pt, first_eta, first_phi, first_gen_pt,
      output second_pt, second_eta, second_phi, second_gen_pt,
      output third_pt, third_eta, third_phi, third_gen_pt,
      input  ready
   );

   modport sink (
      input  valid,
      input  first_pt, first_eta, first_phi, first_gen_pt,
      input  second_pt, second_eta, second_phi, second_gen_pt,
      input  third_pt, third_eta, third_phi, third_gen_pt,
      output ready
   );

endinterface

FILE: rtl/core/top_three_jet_selector_unit.sv
// top level of the top three jet selector: csr block, slot chain, output register
// depends on ttjs_pkg, ttjs_req_if, ttjs_rsp_if, ttjs_cell and the defines header
//
// The req channel takes one jet per item: reco pt, eta, phi, generator pt,
// match angle and a last-of-event flag. A chain of three slot cells keeps the
// best three kept jets of the event, ordered by reco pt then by new_gen
// (generator pt in sim mode, reco pt in data mode), earlier jet first on a
// full tie. Every cell compares the new jet against its own slot in the same
// cycle and hands its old jet to the cell below. A jet with last_jet set is
// ranked first if kept, then the three slots go to the rsp channel as one
// item (empty slots read as zero) and the chain clears. Throughput: one jet
// per cycle, back to back, also across event boundaries, while rsp is not
// stalled. The rsp item becomes valid in the cycle after the last jet is
// accepted, via the single compare per cell and the rsp output register.
// While rsp is held valid and not taken, req.ready stays low, else high.
// csr writes set sim_mode and max_angle. Reset (synchronous) empties all
// slots, drops rsp.valid, sets sim_mode to data mode and max_angle to 205.
`include "top_three_jet_selector_unit_defines.svh"

module top_three_jet_selector_unit #(
   parameter int PT_BITS = ttjs_pkg::PT_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   ttjs_req_if.sink                               req,
   ttjs_rsp_if.source                             rsp,
   input  logic                                   csr_wr_en,
   input  logic [ttjs_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [ttjs_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import ttjs_pkg::*;

   logic                    sim_mode_ff;
   logic [ANGLE_BITS-1:0]   max_angle_ff;
   logic                    accept;
   logic                    keep;
   logic                    ins_valid;
   logic                    clear;
   logic [PT_BITS-1:0]      new_gen;
   logic                    rsp_valid_ff;

   link_type                   link_a   [0:NSLOTS];
   logic [PT_BITS-1:0]         pt_a     [0:NSLOTS];
   logic signed [ETA_BITS-1:0] eta_a    [0:NSLOTS];
   logic signed [PHI_BITS-1:0] phi_a    [0:NSLOTS];
   logic [PT_BITS-1:0]         gen_a    [0:NSLOTS];
   logic                       filled_n [NSLOTS];
   logic [PT_BITS-1:0]         pt_n     [NSLOTS];
   logic signed [ETA_BITS-1:0] eta_n    [NSLOTS];
   logic signed [PHI_BITS-1:0] phi_n    [NSLOTS];
   logic [PT_BITS-1:0]         gen_n    [NSLOTS];

   logic [PT_BITS-1:0]         out_pt_ff  [NSLOTS];
   logic signed [ETA_BITS-1:0] out_eta_ff [NSLOTS];
   logic signed [PHI_BITS-1:0] out_phi_ff [NSLOTS];
   logic [PT_BITS-1:0]         out_gen_ff [NSLOTS];
   logic [NSLOTS-1:0]          filled_vec;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sim_mode_ff  <= 1'b0;
         max_angle_ff <= MAX_ANGLE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SIM_MODE: begin
               sim_mode_ff <= csr_data[0];
            end
            CSR_MAX_ANGLE: begin
               max_angle_ff <= csr_data[ANGLE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign keep      = !sim_mode_ff ||
                      ((req.match_angle != '0) && (req.match_angle < max_angle_ff));
   assign new_gen   = sim_mode_ff ? req.gen_pt : req.reco_pt;
   assign ins_valid = accept && keep;
   assign clear     = accept && req.last_jet;

   // top of the chain sees an empty neighbour that never takes
   assign link_a[0] = '0;
   assign pt_a[0]   = '0;
   assign eta_a[0]  = '0;
   assign phi_a[0]  = '0;
   assign gen_a[0]  = '0;

   for (genvar i = 0; i < NSLOTS; i++) begin : g_cell
      ttjs_cell #(
         .PT_BITS (PT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ins_valid  (ins_valid),
         .clear      (clear),
         .new_pt     (req.reco_pt),
         .new_eta    (req.reco_eta),
         .new_phi    (req.reco_phi),
         .new_gen    (new_gen),
         .prev_link  (link_a[i]),
         .prev_pt    (pt_a[i]),
         .prev_eta   (eta_a[i]),
         .prev_phi   (phi_a[i]),
         .prev_gen   (gen_a[i]),
         .link       (link_a[i+1]),
         .slot_pt    (pt_a[i+1]),
         .slot_eta   (eta_a[i+1]),
         .slot_phi   (phi_a[i+1]),
         .slot_gen   (gen_a[i+1]),
         .nxt_filled (filled_n[i]),
         .nxt_pt     (pt_n[i]),
         .nxt_eta    (eta_n[i]),
         .nxt_phi    (phi_n[i]),
         .nxt_gen    (gen_n[i])
      );

      assign filled_vec[i] = link_a[i+1].filled;

      always_ff @(posedge clock) begin
         if (clear) begin
            out_pt_ff[i]  <= filled_n[i] ? pt_n[i]  : '0;
            out_eta_ff[i] <= filled_n[i] ? eta_n[i] : '0;
            out_phi_ff[i] <= filled_n[i] ? phi_n[i] : '0;
            out_gen_ff[i] <= filled_n[i] ? gen_n[i] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (clear) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.first_pt      = out_pt_ff[0];
   assign rsp.first_eta     = out_eta_ff[0];
   assign rsp.first_phi     = out_phi_ff[0];
   assign rsp.first_gen_pt  = out_gen_ff[0];
   assign rsp.second_pt     = out_pt_ff[1];
   assign rsp.second_eta    = out_eta_ff[1];
   assign rsp.second_phi    = out_phi_ff[1];
   assign rsp.second_gen_pt = out_gen_ff[1];
   assign rsp.third_pt      = out_pt_ff[2];
   assign rsp.third_eta     = out_eta_ff[2];
   assign rsp.third_phi     = out_phi_ff[2];
   assign rsp.third_gen_pt  = out_gen_ff[2];

   `TTJS_ASSERT_NEXT(a_last_gives_rsp, clock, reset, clear, rsp_valid_ff, "last jet gave no rsp item")
   `TTJS_ASSERT_NEXT(a_last_clears, clock, reset, clear, filled_vec == '0, "slots not cleared after last jet")
   `TTJS_ASSERT_IMPL(a_fill_packed, clock, reset, 1'b1, (filled_vec == 3'b000) || (filled_vec == 3'b001) || (filled_vec == 3'b011) || (filled_vec == 3'b111), "slot fill has a hole")
   `TTJS_ASSERT_IMPL(a_rank_12, clock, reset, filled_vec[1], pt_a[1] >= pt_a[2], "slots one and two out of order")
   `TTJS_ASSERT_IMPL(a_rank_23, clock, reset, filled_vec[2], pt_a[2] >= pt_a[3], "slots two and three out of order")

endmodule

FILE: rtl/core/ttjs_cell.sv
// one ranked slot of the selector chain: compares the new jet, shifts down
// depends on ttjs_pkg
module ttjs_cell #(
   parameter int PT_BITS = ttjs_pkg::PT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  ins_valid,
   input  logic                                  clear,
   input  logic [PT_BITS-1:0]                    new_pt,
   input  logic signed [ttjs_pkg::ETA_BITS-1:0]  new_eta,
   input  logic signed [ttjs_pkg::PHI_BITS-1:0]  new_phi,
   input  logic [PT_BITS-1:0]                    new_gen,
   input  ttjs_pkg::link_type                    prev_link,
   input  logic [PT_BITS-1:0]                    prev_pt,
   input  logic signed [ttjs_pkg::ETA_BITS-1:0]  prev_eta,
   input  logic signed [ttjs_pkg::PHI_BITS-1:0]  prev_phi,
   input  logic [PT_BITS-1:0]                    prev_gen,
   output ttjs_pkg::link_type                    link,
   output logic [PT_BITS-1:0]                    slot_pt,
   output logic signed [ttjs_pkg::ETA_BITS-1:0]  slot_eta,
   output logic signed [ttjs_pkg::PHI_BITS-1:0]  slot_phi,
   output logic [PT_BITS-1:0]                    slot_gen,
   output logic                                  nxt_filled,
   output logic [PT_BITS-1:0]                    nxt_pt,
   output logic signed [ttjs_pkg::ETA_BITS-1:0]  nxt_eta,
   output logic signed [ttjs_pkg::PHI_BITS-1:0]  nxt_phi,
   output logic [PT_BITS-1:0]                    nxt_gen
);
   import ttjs_pkg::*;

   logic                       filled_ff, filled_in;
   logic [PT_BITS-1:0]         pt_ff, pt_in;
   logic signed [ETA_BITS-1:0] eta_ff, eta_in;
   logic signed [PHI_BITS-1:0] phi_ff, phi_in;
   logic [PT_BITS-1:0]         gen_ff, gen_in;
   logic                       outranks;
   logic                       take;

   assign outranks = (new_pt > pt_ff) || ((new_pt == pt_ff) && (new_gen > gen_ff));
   assign take     = ins_valid && (!filled_ff || outranks);

   always_comb begin
      filled_in = filled_ff;
      pt_in     = pt_ff;
      eta_in    = eta_ff;
      phi_in    = phi_ff;
      gen_in    = gen_ff;
      if (prev_link.take) begin
         // the slot above takes the new jet, so its old jet moves down
         filled_in = prev_link.filled;
         pt_in     = prev_pt;
         eta_in    = prev_eta;
         phi_in    = prev_phi;
         gen_in    = prev_gen;
      end else if (take) begin
         filled_in = 1'b1;
         pt_in     = new_pt;
         eta_in    = new_eta;
         phi_in    = new_phi;
         gen_in    = new_gen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
      end else if (clear) begin
         filled_ff <= 1'b0;
      end else begin
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff  <= pt_in;
      eta_ff <= eta_in;
      phi_ff <= phi_in;
      gen_ff <= gen_in;
   end

   assign link.take   = take;
   assign link.filled = filled_ff;
   assign slot_pt     = pt_ff;
   assign slot_eta    = eta_ff;
   assign slot_phi    = phi_ff;
   assign slot_gen    = gen_ff;
   assign nxt_filled  = filled_in;
   assign nxt_pt      = pt_in;
   assign nxt_eta     = eta_in;
   assign nxt_phi     = phi_in;
   assign nxt_gen     = gen_in;

endmodule
